// File: sv/assert_macros.svh
// Assertion macros used by the heightmap_vertex_normal RTL.
// Expects clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/hvn_pkg.sv
// Shared widths, register codes and types for the heightmap vertex normal block.
// No dependencies; used by hvn_sqrt, hvn_div and heightmap_vertex_normal.
package hvn_pkg;

  localparam int HEIGHT_BITS = 24;
  localparam int COORD_W     = 16;
  localparam int SPACE_W     = 24;

  // Cross product and sum widths
  localparam int DIFF_W = HEIGHT_BITS + 1;
  localparam int PROD_W = DIFF_W + SPACE_W + 1;
  localparam int AREA_W = 2 * SPACE_W;
  localparam int WIDE_W = (HEIGHT_BITS > SPACE_W) ? HEIGHT_BITS : SPACE_W;
  localparam int SUM_W  = WIDE_W + 27;
  localparam int MAG_W  = SUM_W - 1;

  // Leading-one search in byte groups
  localparam int NGRP  = (MAG_W + 7) / 8;
  localparam int GRP_W = $clog2(NGRP);
  localparam int POS_W = $clog2(NGRP * 8);

  // Normalized magnitudes, root and quotient
  localparam int NM_W   = 30;
  localparam int NM_TOP = NM_W - 1;
  localparam int SQ_W   = 2 * NM_W + 2;
  localparam int RT_W   = NM_W + 1;
  localparam int Q_W    = 16;
  localparam int NUM_W  = NM_W + Q_W;
  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

  // Pipeline length: front stages, root, divide, output register
  localparam int PRE_STAGES = 10;
  localparam int LAT        = PRE_STAGES + RT_W + Q_W + 1;

  // Stream payloads
  localparam int IN_BITS = 2 * COORD_W + 5 * HEIGHT_BITS;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W   = 3 * Q_W;

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_GRID_W  = 2'd0;
  localparam logic [1:0] REG_GRID_H  = 2'd1;
  localparam logic [1:0] REG_SPACE_X = 2'd2;
  localparam logic [1:0] REG_SPACE_Z = 2'd3;

  localparam logic [15:0]        GRID_W_RST  = 16'd1024;
  localparam logic [15:0]        GRID_H_RST  = 16'd1024;
  localparam logic [SPACE_W-1:0] SPACE_X_RST = SPACE_W'(256);
  localparam logic [SPACE_W-1:0] SPACE_Z_RST = SPACE_W'(256);

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       any;
    logic       degen;
  } side_t;

endpackage

// File: sv/hvn_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on hvn_pkg.
module hvn_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hvn_pkg::SQ_W-1:0]  radicand,
  output logic [hvn_pkg::RT_W-1:0]  root
);

  logic [hvn_pkg::SQ_W-1:0] rem_q  [hvn_pkg::RT_W];
  logic [hvn_pkg::RT_W-1:0] res_q  [hvn_pkg::RT_W];
  logic [hvn_pkg::SQ_W-1:0] rem_in [hvn_pkg::RT_W];
  logic [hvn_pkg::RT_W-1:0] res_in [hvn_pkg::RT_W];
  logic [hvn_pkg::SQ_W+1:0] trial  [hvn_pkg::RT_W];
  logic                     fit    [hvn_pkg::RT_W];

  // Stage inputs and trial subtrahend (2*res + bit) * bit
  always_comb begin
    rem_in[0] = radicand;
    res_in[0] = '0;
    for (int i = 1; i < hvn_pkg::RT_W; i++) begin
      rem_in[i] = rem_q[i-1];
      res_in[i] = res_q[i-1];
    end
    for (int i = 0; i < hvn_pkg::RT_W; i++) begin
      trial[i] = ((hvn_pkg::SQ_W+2)'(res_in[i]) << (hvn_pkg::RT_W - i))
               + ((hvn_pkg::SQ_W+2)'(1) << (2 * (hvn_pkg::RT_W - 1 - i)));
      fit[i]   = (hvn_pkg::SQ_W+2)'(rem_in[i]) >= trial[i];
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < hvn_pkg::RT_W; i++) begin
        rem_q[i] <= fit[i] ? rem_in[i] - trial[i][hvn_pkg::SQ_W-1:0] : rem_in[i];
        res_q[i] <= res_in[i] |
                    (fit[i] ? hvn_pkg::RT_W'(1) << (hvn_pkg::RT_W - 1 - i) : '0);
      end
    end
  end

  assign root = res_q[hvn_pkg::RT_W-1];

endmodule

// File: sv/hvn_div.sv
// Pipelined rounded Q1.15 divide: (mag * 2^15 + len/2) / len, one bit per stage.
// Depends on hvn_pkg.
module hvn_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hvn_pkg::NM_W-1:0]  mag,
  input  logic [hvn_pkg::RT_W-1:0]  len,
  output logic [hvn_pkg::Q_W-1:0]   quot
);

  logic [hvn_pkg::NUM_W-1:0] rem_q  [hvn_pkg::Q_W];
  logic [hvn_pkg::RT_W-1:0]  den_q  [hvn_pkg::Q_W];
  logic [hvn_pkg::Q_W-1:0]   quo_q  [hvn_pkg::Q_W];
  logic [hvn_pkg::NUM_W-1:0] rem_in [hvn_pkg::Q_W];
  logic [hvn_pkg::RT_W-1:0]  den_in [hvn_pkg::Q_W];
  logic [hvn_pkg::Q_W-1:0]   quo_in [hvn_pkg::Q_W];
  logic [hvn_pkg::NUM_W:0]   step   [hvn_pkg::Q_W];
  logic                      fit    [hvn_pkg::Q_W];

  // Rounded numerator enters stage 0; divisor travels with it
  always_comb begin
    rem_in[0] = (hvn_pkg::NUM_W'(mag) << (hvn_pkg::Q_W - 1)) + hvn_pkg::NUM_W'(len >> 1);
    den_in[0] = len;
    quo_in[0] = '0;
    for (int i = 1; i < hvn_pkg::Q_W; i++) begin
      rem_in[i] = rem_q[i-1];
      den_in[i] = den_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < hvn_pkg::Q_W; i++) begin
      step[i] = (hvn_pkg::NUM_W+1)'(den_in[i]) << (hvn_pkg::Q_W - 1 - i);
      fit[i]  = (hvn_pkg::NUM_W+1)'(rem_in[i]) >= step[i];
    end
  end

  // Restoring divide stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < hvn_pkg::Q_W; i++) begin
        rem_q[i] <= fit[i] ? rem_in[i] - step[i][hvn_pkg::NUM_W-1:0] : rem_in[i];
        den_q[i] <= den_in[i];
        quo_q[i] <= quo_in[i] |
                    (fit[i] ? hvn_pkg::Q_W'(1) << (hvn_pkg::Q_W - 1 - i) : '0);
      end
    end
  end

  assign quot = quo_q[hvn_pkg::Q_W-1];

endmodule

// File: sv/heightmap_vertex_normal.sv
// Heightmap vertex normal top level: APB registers, cross-product front end,
// normalize, and root/divide pipeline. Depends on hvn_pkg, hvn_sqrt, hvn_div, assert_macros.svh.
//
// Channel   Dir  Payload (low bit up)
// s_*       in   column, row, center, left, right, up, down heights
// m_*       out  tdata: normal_x, normal_y, normal_z; tuser: degenerate
// APB       in   grid_width, grid_height, spacing_x, spacing_z at 0x0/0x4/0x8/0xC
//
// One transaction per cycle in and out while the output is not held; the pipeline is
// 10 front stages, the 31-stage square root and 16-stage divide, and an output register.
// rst is synchronous and clears the valid bits and the registers to their defaults.
// A held output stalls every stage together; s_tready drops only then.
`include "assert_macros.svh"

module heightmap_vertex_normal (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // column, row, center_height, left_height, right_height, up_height, down_height
  input  logic [hvn_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // normal_x, normal_y, normal_z
  output logic [hvn_pkg::OUT_W-1:0]    m_tdata,
  // degenerate
  output logic                         m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hvn_pkg::ADDR_W-1:0]   paddr,
  input  logic [hvn_pkg::DATA_W-1:0]   pwdata,
  output logic [hvn_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int HB = hvn_pkg::HEIGHT_BITS;
  localparam int CW = hvn_pkg::COORD_W;
  localparam int SW = hvn_pkg::SUM_W;
  localparam int QW = hvn_pkg::Q_W;
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  // pair bits
  localparam int P_UR = 0;
  localparam int P_UL = 1;
  localparam int P_DR = 2;
  localparam int P_DL = 3;

  // Configuration registers
  logic [15:0]                 grid_width;
  logic [15:0]                 grid_height;
  logic [hvn_pkg::SPACE_W-1:0] spacing_x;
  logic [hvn_pkg::SPACE_W-1:0] spacing_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= hvn_pkg::GRID_W_RST;
      grid_height <= hvn_pkg::GRID_H_RST;
      spacing_x   <= hvn_pkg::SPACE_X_RST;
      spacing_z   <= hvn_pkg::SPACE_Z_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[hvn_pkg::ADDR_W-1:2])
        hvn_pkg::REG_GRID_W:  grid_width  <= pwdata[15:0];
        hvn_pkg::REG_GRID_H:  grid_height <= pwdata[15:0];
        hvn_pkg::REG_SPACE_X: spacing_x   <= pwdata[hvn_pkg::SPACE_W-1:0];
        hvn_pkg::REG_SPACE_Z: spacing_z   <= pwdata[hvn_pkg::SPACE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[hvn_pkg::ADDR_W-1:2])
      hvn_pkg::REG_GRID_W:  prdata = hvn_pkg::DATA_W'(grid_width);
      hvn_pkg::REG_GRID_H:  prdata = hvn_pkg::DATA_W'(grid_height);
      hvn_pkg::REG_SPACE_X: prdata = hvn_pkg::DATA_W'(spacing_x);
      hvn_pkg::REG_SPACE_Z: prdata = hvn_pkg::DATA_W'(spacing_z);
    endcase
  end

  assign pready = 1'b1;

  // Global advance: everything moves unless the output is held
  logic                    en;
  logic [hvn_pkg::LAT-1:0] vld;

  assign en       = m_tready || !vld[hvn_pkg::LAT-1];
  assign s_tready = en;
  assign m_tvalid = vld[hvn_pkg::LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[hvn_pkg::LAT-2:0], s_tvalid};
    end
  end

  // Stage 0: input register
  logic [CW-1:0] col0;
  logic [CW-1:0] row0;
  logic [HB-1:0] hgt0 [5];

  always_ff @(posedge clk) begin
    if (en) begin
      col0 <= s_tdata[CW-1:0];
      row0 <= s_tdata[2*CW-1:CW];
      for (int i = 0; i < 5; i++) begin
        hgt0[i] <= s_tdata[2*CW + i*HB +: HB];
      end
    end
  end

  // Stage 1: edge tests and center-minus-neighbor heights (r, l, u, d)
  logic                               has_l, has_r, has_u, has_d;
  logic [3:0]                         pf1;
  logic signed [hvn_pkg::DIFF_W-1:0]  dh1 [4];

  always_comb begin
    has_l = col0 != '0;
    has_u = row0 != '0;
    has_r = ({1'b0, col0} + 17'd1) < {1'b0, grid_width};
    has_d = ({1'b0, row0} + 17'd1) < {1'b0, grid_height};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf1[P_UR] <= has_u && has_r;
      pf1[P_UL] <= has_u && has_l;
      pf1[P_DR] <= has_d && has_r;
      pf1[P_DL] <= has_d && has_l;
      dh1[0] <= $signed({1'b0, hgt0[0]}) - $signed({1'b0, hgt0[2]});
      dh1[1] <= $signed({1'b0, hgt0[0]}) - $signed({1'b0, hgt0[1]});
      dh1[2] <= $signed({1'b0, hgt0[0]}) - $signed({1'b0, hgt0[3]});
      dh1[3] <= $signed({1'b0, hgt0[0]}) - $signed({1'b0, hgt0[4]});
    end
  end

  // Stage 2: spacing products
  logic [3:0]                         pf2;
  logic signed [hvn_pkg::PROD_W-1:0]  pr2, pl2, pu2, pd2;
  logic [hvn_pkg::AREA_W-1:0]         area2;

  always_ff @(posedge clk) begin
    if (en) begin
      pf2   <= pf1;
      pr2   <= $signed({1'b0, spacing_z}) * dh1[0];
      pl2   <= $signed({1'b0, spacing_z}) * dh1[1];
      pu2   <= $signed({1'b0, spacing_x}) * dh1[2];
      pd2   <= $signed({1'b0, spacing_x}) * dh1[3];
      area2 <= spacing_x * spacing_z;
    end
  end

  // Stage 3: sum of upward-oriented pair products
  logic signed [hvn_pkg::SUM_W-1:0] ex_r, ex_l, ez_u, ez_d, ey;
  logic signed [hvn_pkg::SUM_W-1:0] sx_c, sy_c, sz_c;
  logic signed [hvn_pkg::SUM_W-1:0] sum3 [3];
  logic                             flip;

  always_comb begin
    ex_r = hvn_pkg::SUM_W'(pr2);
    ex_l = hvn_pkg::SUM_W'(pl2);
    ez_u = hvn_pkg::SUM_W'(pu2);
    ez_d = hvn_pkg::SUM_W'(pd2);
    ey   = $signed(hvn_pkg::SUM_W'(area2));
    // up/right and down/left point down unless the area is zero
    flip = area2 != '0;
    sx_c = '0;
    sy_c = '0;
    sz_c = '0;
    if (pf2[P_UR]) begin
      sx_c = sx_c + (flip ? ex_r : -ex_r);
      sy_c = sy_c + ey;
      sz_c = sz_c + (flip ? -ez_u : ez_u);
    end
    if (pf2[P_UL]) begin
      sx_c = sx_c - ex_l;
      sy_c = sy_c + ey;
      sz_c = sz_c - ez_u;
    end
    if (pf2[P_DR]) begin
      sx_c = sx_c + ex_r;
      sy_c = sy_c + ey;
      sz_c = sz_c + ez_d;
    end
    if (pf2[P_DL]) begin
      sx_c = sx_c + (flip ? -ex_l : ex_l);
      sy_c = sy_c + ey;
      sz_c = sz_c + (flip ? ez_d : -ez_d);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3[0] <= sx_c;
      sum3[1] <= sy_c;
      sum3[2] <= sz_c;
    end
  end

  // Stage 4: magnitudes
  logic [hvn_pkg::MAG_W-1:0] m4 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m4[k] <= sum3[k][hvn_pkg::SUM_W-1] ? hvn_pkg::MAG_W'(-sum3[k])
                                           : hvn_pkg::MAG_W'(sum3[k]);
      end
    end
  end

  // Stage 5: per-byte leading one of the OR of magnitudes
  logic [hvn_pkg::NGRP*8-1:0] orv;
  logic [hvn_pkg::NGRP-1:0]   nz_c;
  logic [2:0]                 lm_c [hvn_pkg::NGRP];
  logic [hvn_pkg::MAG_W-1:0]  m5 [3];
  logic [hvn_pkg::NGRP-1:0]   nz5;
  logic [2:0]                 lm5 [hvn_pkg::NGRP];

  always_comb begin
    orv = (hvn_pkg::NGRP*8)'(m4[0] | m4[1] | m4[2]);
    for (int g = 0; g < hvn_pkg::NGRP; g++) begin
      nz_c[g] = |orv[8*g +: 8];
      lm_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orv[8*g + b]) lm_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5  <= m4;
      nz5 <= nz_c;
      lm5 <= lm_c;
    end
  end

  // Stage 6: top group picks the leading-one position
  logic [hvn_pkg::GRP_W-1:0] gsel;
  logic [hvn_pkg::MAG_W-1:0] m6 [3];
  logic [hvn_pkg::POS_W-1:0] pos6;

  always_comb begin
    gsel = '0;
    for (int g = 0; g < hvn_pkg::NGRP; g++) begin
      if (nz5[g]) gsel = hvn_pkg::GRP_W'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m6   <= m5;
      pos6 <= {gsel, lm5[gsel]};
    end
  end

  // Stage 7: shift so the largest magnitude has its top bit at NM_TOP
  logic [hvn_pkg::MAG_W+hvn_pkg::NM_W-1:0] wide [3];
  logic [hvn_pkg::NM_W-1:0]                mn7 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos6 >= hvn_pkg::POS_W'(hvn_pkg::NM_TOP)) begin
        wide[k] = (hvn_pkg::MAG_W+hvn_pkg::NM_W)'(m6[k])
                  >> (pos6 - hvn_pkg::POS_W'(hvn_pkg::NM_TOP));
      end else begin
        wide[k] = (hvn_pkg::MAG_W+hvn_pkg::NM_W)'(m6[k])
                  << (hvn_pkg::POS_W'(hvn_pkg::NM_TOP) - pos6);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mn7[k] <= wide[k][hvn_pkg::NM_W-1:0];
      end
    end
  end

  // Stage 8: squares; stage 9: sum of squares
  logic [hvn_pkg::NM_W-1:0]   mn8 [3];
  logic [hvn_pkg::NM_W-1:0]   mn9 [3];
  logic [2*hvn_pkg::NM_W-1:0] sq8 [3];
  logic [hvn_pkg::SQ_W-1:0]   sq9;

  always_ff @(posedge clk) begin
    if (en) begin
      mn8 <= mn7;
      for (int k = 0; k < 3; k++) begin
        sq8[k] <= mn7[k] * mn7[k];
      end
      mn9 <= mn8;
      sq9 <= hvn_pkg::SQ_W'(sq8[0]) + hvn_pkg::SQ_W'(sq8[1]) + hvn_pkg::SQ_W'(sq8[2]);
    end
  end

  // Square root, magnitudes delayed alongside
  logic [hvn_pkg::RT_W-1:0] len;
  logic [hvn_pkg::NM_W-1:0] nd [hvn_pkg::RT_W][3];

  hvn_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sq9),
    .root     (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nd[0] <= mn9;
      for (int i = 1; i < hvn_pkg::RT_W; i++) begin
        nd[i] <= nd[i-1];
      end
    end
  end

  // Three dividers sharing the length
  logic [hvn_pkg::Q_W-1:0] quot [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    hvn_div u_div (
      .clk  (clk),
      .en   (en),
      .mag  (nd[hvn_pkg::RT_W-1][k]),
      .len  (len),
      .quot (quot[k])
    );
  end

  // Side flags travel with the item; signs join at stage 4, degenerate at stage 6
  hvn_pkg::side_t sd [1:hvn_pkg::LAT-2];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= '{neg: 3'b000, any: (has_u || has_d) && (has_l || has_r), degen: 1'b0};
      for (int k = 2; k < hvn_pkg::LAT-1; k++) begin
        if (k == 4) begin
          sd[k] <= '{neg: {sum3[2][SW-1], sum3[1][SW-1], sum3[0][SW-1]},
                     any: sd[3].any, degen: sd[3].degen};
        end else if (k == 6) begin
          sd[k] <= '{neg: sd[5].neg, any: sd[5].any, degen: !sd[5].any || !(|nz5)};
        end else begin
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  // Output register: saturate, sign, zero when degenerate
  logic [hvn_pkg::Q_W-1:0] sat [3];
  logic [hvn_pkg::Q_W-1:0] val [3];
  hvn_pkg::side_t          sd_last;

  always_comb begin
    sd_last = sd[hvn_pkg::LAT-2];
    for (int k = 0; k < 3; k++) begin
      sat[k] = (quot[k] > hvn_pkg::Q_MAX) ? hvn_pkg::Q_MAX : quot[k];
      val[k] = sd_last.neg[k] ? ~sat[k] + 1'b1 : sat[k];
      if (sd_last.degen) val[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {val[2], val[1], val[0]};
      m_tuser <= sd_last.degen;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate with nonzero normal")
  `ASSERT_IMPLIES(a_y_up, m_tvalid, !m_tdata[2*QW-1], "normal_y negative")
  `ASSERT_IMPLIES(a_x_no_min, m_tvalid, m_tdata[QW-1:0] != Q_MIN, "normal_x saturation failed")
  `ASSERT_IMPLIES(a_z_no_min, m_tvalid, m_tdata[3*QW-1:2*QW] != Q_MIN, "normal_z saturation failed")
  `ASSERT_NEXT(a_stall_hold, !en, $stable(vld) && $stable(m_tdata), "pipeline moved while stalled")

endmodule

// File: tb/tb_heightmap_vertex_normal.sv
// Self-checking testbench for heightmap_vertex_normal: random and directed grid samples
// checked against an in-bench normal predictor. Depends on hvn_pkg and the block's RTL.
module tb_heightmap_vertex_normal;

  typedef struct {
    logic [15:0] column;
    logic [15:0] row;
    logic [23:0] center;
    logic [23:0] left;
    logic [23:0] right;
    logic [23:0] up;
    logic [23:0] down;
  } sample_t;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degenerate;
  } normal_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [hvn_pkg::IN_W-1:0]   s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [hvn_pkg::OUT_W-1:0]  m_tdata;
  logic                       m_tuser;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [hvn_pkg::ADDR_W-1:0] paddr = '0;
  logic [hvn_pkg::DATA_W-1:0] pwdata = '0;
  logic [hvn_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Shadow copy of the register file
  logic [15:0] grid_w_q  = hvn_pkg::GRID_W_RST;
  logic [15:0] grid_h_q  = hvn_pkg::GRID_H_RST;
  logic [23:0] space_x_q = hvn_pkg::SPACE_X_RST;
  logic [23:0] space_z_q = hvn_pkg::SPACE_Z_RST;

  normal_t expected_normals[$];
  int      mismatches = 0;
  int      sent_count = 0;
  int      checked_count = 0;
  int      degenerate_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  heightmap_vertex_normal u_top (.*);

  always #5 clk = ~clk;

  // Cross product of two centre-to-neighbour vectors, flipped so y points up
  function automatic vec_t upward_cross(vec_t a, vec_t b);
    vec_t c;
    c.x = a.y * b.z - a.z * b.y;
    c.y = a.z * b.x - a.x * b.z;
    c.z = a.x * b.y - a.y * b.x;
    if (c.y < 0) begin
      c.x = -c.x;
      c.y = -c.y;
      c.z = -c.z;
    end
    return c;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_q15(longint unsigned mag, bit neg,
                                            longint unsigned len);
    longint unsigned q;
    q = (mag * 32768 + len / 2) / len;
    if (q > 32767) q = 32767;
    if (neg) q = -q;
    return q[15:0];
  endfunction

  function automatic normal_t predict_normal(sample_t s);
    normal_t res;
    vec_t vl, vr, vu, vd, acc, c;
    longint cen, sx, sz;
    bit has_l, has_r, has_u, has_d, any;
    longint unsigned m[3];
    bit neg[3];
    longint unsigned mx, len;
    cen = longint'(s.center);
    sx = longint'(space_x_q);
    sz = longint'(space_z_q);
    has_l = s.column >= 1;
    has_r = int'(s.column) + 1 < int'(grid_w_q);
    has_u = s.row >= 1;
    has_d = int'(s.row) + 1 < int'(grid_h_q);
    vl = '{sx, cen - longint'(s.left), 0};
    vr = '{-sx, cen - longint'(s.right), 0};
    vu = '{0, cen - longint'(s.up), sz};
    vd = '{0, cen - longint'(s.down), -sz};
    acc = '{0, 0, 0};
    any = 0;
    for (int k = 0; k < 4; k++) begin
      bit on;
      on = (k == 0) ? (has_u && has_r) : (k == 1) ? (has_u && has_l) :
           (k == 2) ? (has_d && has_r) : (has_d && has_l);
      if (on) begin
        c = upward_cross((k < 2) ? vu : vd, (k % 2 == 0) ? vr : vl);
        acc.x += c.x;
        acc.y += c.y;
        acc.z += c.z;
        any = 1;
      end
    end
    neg[0] = acc.x < 0; m[0] = neg[0] ? -acc.x : acc.x;
    neg[1] = acc.y < 0; m[1] = neg[1] ? -acc.y : acc.y;
    neg[2] = acc.z < 0; m[2] = neg[2] ? -acc.z : acc.z;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (!any || mx == 0) begin
      res = '{16'd0, 16'd0, 16'd0, 1'b1};
      return res;
    end
    // Bring the largest magnitude into [2^29, 2^30)
    while (mx >= (64'd1 << 30)) begin
      for (int k = 0; k < 3; k++) m[k] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int k = 0; k < 3; k++) m[k] <<= 1;
      mx <<= 1;
    end
    len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    res.nx = scale_q15(m[0], neg[0], len);
    res.ny = scale_q15(m[1], neg[1], len);
    res.nz = scale_q15(m[2], neg[2], len);
    res.degenerate = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("ERROR t=%0t result %0d: %s got %h expected %h",
             $realtime, checked_count, field, got, want);
    mismatches++;
  endtask

  // Output checker
  always @(posedge clk) begin
    normal_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata[15:0], 16'h0);
      end else begin
        want = expected_normals.pop_front();
        if (m_tdata[15:0] !== want.nx) report_mismatch("normal_x", m_tdata[15:0], want.nx);
        if (m_tdata[31:16] !== want.ny) report_mismatch("normal_y", m_tdata[31:16], want.ny);
        if (m_tdata[47:32] !== want.nz) report_mismatch("normal_z", m_tdata[47:32], want.nz);
        if (m_tuser !== want.degenerate)
          report_mismatch("degenerate", {15'd0, m_tuser}, {15'd0, want.degenerate});
        if (want.degenerate) degenerate_count++;
      end
      checked_count++;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(sample_t s);
    s_tvalid <= 1'b1;
    s_tdata <= {s.down, s.up, s.right, s.left, s.center, s.row, s.column};
    do @(posedge clk); while (!s_tready);
    expected_normals = {expected_normals, predict_normal(s)};
    sent_count++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (hvn_pkg::LAT + 8) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      hvn_pkg::REG_GRID_W:  grid_w_q  = value[15:0];
      hvn_pkg::REG_GRID_H:  grid_h_q  = value[15:0];
      hvn_pkg::REG_SPACE_X: space_x_q = value[23:0];
      hvn_pkg::REG_SPACE_Z: space_z_q = value[23:0];
    endcase
  endtask

  task automatic set_grid(logic [15:0] gw, logic [15:0] gh, logic [23:0] sx, logic [23:0] sz);
    apb_write(hvn_pkg::REG_GRID_W, {16'd0, gw});
    apb_write(hvn_pkg::REG_GRID_H, {16'd0, gh});
    apb_write(hvn_pkg::REG_SPACE_X, {8'd0, sx});
    apb_write(hvn_pkg::REG_SPACE_Z, {8'd0, sz});
  endtask

  function automatic logic [15:0] pick_index(logic [15:0] size);
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return size - 16'd2;
      3: return size - 16'd1;
      4: return size;
      5: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [23:0] pick_height(logic [23:0] cen);
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 24'hFFFFFF));
      1: return 24'd0;
      2: return 24'hFFFFFF;
      default: return cen + 24'($urandom_range(0, 2048)) - 24'd1024;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.column = pick_index(grid_w_q);
    s.row = pick_index(grid_h_q);
    s.center = ($urandom_range(0, 3) == 0) ? pick_height(24'h800000) : 24'($urandom());
    s.left = pick_height(s.center);
    s.right = pick_height(s.center);
    s.up = pick_height(s.center);
    s.down = pick_height(s.center);
    return s;
  endfunction

  // Edges, corners, off-grid, height extremes at reset; 1x1, 0x0 and zero-spacing grids
  task automatic test_directed();
    logic [15:0] cols[5] = '{16'd0, 16'd1, 16'd1022, 16'd1023, 16'hFFFF};
    for (int i = 0; i < 5; i++) begin
      send_sample('{cols[i], cols[4 - i], 24'h000100, 24'h0, 24'hFFFFFF, 24'h123456, 24'h0});
    end
    send_sample('{16'd10, 16'd10, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0});
    send_sample('{16'd10, 16'd10, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
    send_sample('{16'd10, 16'd10, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0});
    send_sample('{16'd10, 16'd10, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
    send_sample('{16'd10, 16'd10, 24'h0, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF});
    send_sample('{16'hAAAA, 16'h5555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'h0});
    send_sample('{16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                  24'hFFFFFF});
    stop_sending();
    drain();
    // Single-sample grid: no pair, degenerate
    set_grid(16'd1, 16'd1, 24'd256, 24'd256);
    send_sample('{16'd0, 16'd0, 24'h1, 24'h2, 24'h3, 24'h4, 24'h5});
    // Zero grid size: only left/up neighbours count
    stop_sending();
    drain();
    set_grid(16'd0, 16'd0, 24'hFFFFFF, 24'd1);
    send_sample('{16'd0, 16'd0, 24'h1, 24'h2, 24'h3, 24'h4, 24'h5});
    send_sample('{16'd5, 16'd5, 24'hFFFFFF, 24'h0, 24'h3, 24'h0, 24'h5});
    stop_sending();
    drain();
    // Zero spacing gives a zero sum
    set_grid(16'd8, 16'd8, 24'd0, 24'd0);
    send_sample('{16'd3, 16'd3, 24'h1000, 24'h2, 24'h3, 24'h4, 24'h5});
    set_grid_idle();
  endtask

  task automatic set_grid_idle();
    stop_sending();
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_sample(random_sample());
    set_grid_idle();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 4 * hvn_pkg::LAT;
    for (int i = 0; i < 150; i++) send_sample(random_sample());
    set_grid_idle();
  endtask

  initial begin
    logic [15:0] gws[6] = '{16'd1024, 16'd2, 16'd65535, 16'd3, 16'd17, 16'd1};
    logic [23:0] sxs[6] = '{24'd256, 24'd1, 24'hFFFFFF, 24'd0, 24'd777, 24'h00ABCD};
    logic [23:0] szs[6] = '{24'd256, 24'hFFFFFF, 24'hFFFFFF, 24'd5, 24'd1, 24'h1234};
    int idles[4] = '{0, 67, 0, 36};
    int stalls[4] = '{0, 0, 67, 36};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 6; p++) begin
      set_grid(gws[p], gws[(p + 3) % 6], sxs[p], szs[p]);
      for (int m = 0; m < 4; m++) test_random(75, idles[m], stalls[m]);
    end
    set_grid(16'd64, 16'd64, 24'd256, 24'd512);
    test_backpressure();
    test_random(10, 36, 36);
    $display("Covered %0d samples over eleven grid settings, %0d degenerate normals,",
             sent_count, degenerate_count);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", expected_normals.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/hvn_pkg.sv
sv/hvn_sqrt.sv
sv/hvn_div.sv
sv/heightmap_vertex_normal.sv
tb/tb_heightmap_vertex_normal.sv
